// ===== src/vvpu_pkg.sv =====
`default_nettype none
package vvpu_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned ADDR_W = 5;

  // Register indexes
  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_LOWER_X   = 3'd1;
  localparam logic [2:0] REG_UPPER_X   = 3'd2;
  localparam logic [2:0] REG_LOWER_Y   = 3'd3;
  localparam logic [2:0] REG_UPPER_Y   = 3'd4;
  localparam logic [2:0] REG_LOWER_Z   = 3'd5;
  localparam logic [2:0] REG_UPPER_Z   = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic signed [31:0] force_req;
    logic [31:0]        mass;
    logic               active;
  } vvpu_in_t;

  typedef struct packed {
    logic [1:0]         axis_out;
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic signed [31:0] new_acceleration;
    logic               still_active;
    logic               last;
  } vvpu_out_t;

  // Bound pair picked for the axis at queue entry
  typedef struct packed {
    vvpu_in_t           item;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic               in_range;
  } vvpu_job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_FIN, ST_OUT
  } vvpu_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return SAT_MAX;
    if (v < -72'sd2147483648) return SAT_MIN;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/vvpu_if.sv =====
`default_nettype none
interface vvpu_in_if import vvpu_pkg::*; ();
  logic     valid;
  logic     ready;
  vvpu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vvpu_out_if import vvpu_pkg::*; ();
  logic      valid;
  logic      ready;
  vvpu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/vvpu_front.sv =====
`default_nettype none
module vvpu_front import vvpu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  vvpu_in_if.sink                in_ch,
  input  wire logic [31:0]       bounds [1:6],
  output vvpu_job_t              job,
  output logic                   job_valid,
  input  wire logic              job_ready
);
  // Two-entry queue between intake and the datapath
  vvpu_job_t q_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  vvpu_job_t entry;

  // Classify the request: pick bounds of its axis
  always_comb begin
    entry          = '0;
    entry.item     = in_ch.data;
    entry.in_range = 1'b1;
    unique case (in_ch.data.axis)
      AXIS_X: begin entry.lower = bounds[REG_LOWER_X]; entry.upper = bounds[REG_UPPER_X]; end
      AXIS_Y: begin entry.lower = bounds[REG_LOWER_Y]; entry.upper = bounds[REG_UPPER_Y]; end
      AXIS_Z: begin entry.lower = bounds[REG_LOWER_Z]; entry.upper = bounds[REG_UPPER_Z]; end
      default: entry.in_range = 1'b0;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign job_valid   = (cnt_r != 2'd0);
  assign job         = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) q_r[wp_r] <= entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) wp_r <= ~wp_r;
      if (job_valid && job_ready)     rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_ch.valid && in_ch.ready) - 2'(job_valid && job_ready);
    end
  end
endmodule
`default_nettype wire

// ===== src/vvpu_div.sv =====
`default_nettype none
module vvpu_div import vvpu_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] force_in,
  input  wire logic [31:0]        mass_in,
  output logic                    done,
  output logic signed [31:0]      quot
);
  localparam int unsigned NW = 32 + FracBits;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [32:0]   rem_r;
  logic [31:0]   den_r;
  logic          neg_r, busy_r, zero_r, fzero_r;
  logic [CW-1:0] cnt_r;
  logic [32:0]   trial;
  logic [NW:0]   mag;
  logic [31:0]   absf;

  assign absf  = force_in[31] ? 32'(-force_in) : force_in;
  assign trial = {rem_r[31:0], num_r[NW-1]} - {1'b0, den_r};

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        num_r   <= NW'(absf) << FracBits;
        rem_r   <= '0;
        den_r   <= mass_in;
        neg_r   <= force_in[31];
        zero_r  <= (mass_in == '0);
        fzero_r <= (force_in == '0);
        cnt_r   <= CW'(NW);
      end else if (busy_r) begin
        if (trial[32]) begin
          rem_r <= {rem_r[31:0], num_r[NW-1]};
          num_r <= {num_r[NW-2:0], 1'b0};
        end else begin
          rem_r <= trial;
          num_r <= {num_r[NW-2:0], 1'b1};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // num_r holds the quotient magnitude when done; zero mass saturates by force sign, or gives zero for zero force
  always_comb begin
    mag = {1'b0, num_r};
    if (zero_r)
      quot = neg_r ? SAT_MIN : (fzero_r ? '0 : SAT_MAX);
    else if (neg_r)
      quot = sat32(72'(-$signed({1'b0, mag})));
    else
      quot = sat32(72'($signed({1'b0, mag})));
  end
endmodule
`default_nettype wire

// ===== src/vvpu_back.sv =====
`default_nettype none
module vvpu_back import vvpu_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire vvpu_job_t    job,
  input  wire logic         job_valid,
  output logic              job_ready,
  input  wire logic [31:0]  dt,
  vvpu_out_if.source        out_ch
);
  vvpu_state_t state_r, state_nxt;
  vvpu_job_t   j_r;
  logic        oob_r;
  logic signed [31:0] na_r, ad_r;
  logic signed [71:0] t1_r, t2_r, tv_r;
  logic signed [32:0] sacc;
  logic signed [32:0] dts;
  logic        dstart, ddone;
  logic signed [31:0] dq;
  logic signed [71:0] npos, nvel;
  logic signed [31:0] np_s;
  logic        outside;
  logic        res_load;
  vvpu_out_t   res_r;
  logic        res_v_r;

  assign dts  = $signed({1'b0, dt});
  assign sacc = 33'(j_r.item.acceleration) + 33'(na_r);

  vvpu_div #(.FracBits(FracBits)) u_div (
    .clk, .rst_n, .start(dstart),
    .force_in(job.item.force_req), .mass_in(job.item.mass),
    .done(ddone), .quot(dq)
  );

  assign job_ready = (state_r == ST_IDLE);
  assign dstart    = job_valid && job_ready;
  assign res_load  = (state_r == ST_OUT) && (!res_v_r || out_ch.ready);

  assign npos = 72'(j_r.item.position) + t1_r + t2_r;
  assign nvel = 72'(j_r.item.velocity) + tv_r;
  assign np_s = sat32(npos);
  assign outside = j_r.in_range && (np_s > j_r.upper || np_s < j_r.lower);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (dstart) state_nxt = ST_DIV;
      ST_DIV:  if (ddone) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (!res_v_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Multiply steps: MUL1 forms two products, MUL2 and MUL3 one each (operands up to 33 bits), all registered
  always_ff @(posedge clk) begin
    if (dstart) j_r <= job;
    unique case (state_r)
      ST_DIV:  if (ddone) na_r <= dq;
      ST_MUL1: begin
        t1_r <= (72'(j_r.item.velocity) * 72'(dts)) >>> FracBits;
        ad_r <= sat32((72'(j_r.item.acceleration) * 72'(dts)) >>> FracBits);
      end
      ST_MUL2: t2_r <= (72'(ad_r) * 72'(dts)) >>> (FracBits + 1);
      ST_MUL3: tv_r <= (72'(sacc) * 72'(dts)) >>> (FracBits + 1);
      default: ;
    endcase
  end

  // Result register and out-of-box flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
      oob_r   <= 1'b0;
    end else begin
      if (res_load)          res_v_r <= 1'b1;
      else if (out_ch.ready) res_v_r <= 1'b0;
      if (res_load) begin
        res_r.axis_out       <= j_r.item.axis;
        res_r.last           <= (j_r.item.axis == AXIS_Z);
        if (j_r.item.active) begin
          res_r.new_position     <= np_s;
          res_r.new_velocity     <= sat32(nvel);
          res_r.new_acceleration <= na_r;
          res_r.still_active     <= !(oob_r || outside);
        end else begin
          res_r.new_position     <= j_r.item.position;
          res_r.new_velocity     <= j_r.item.velocity;
          res_r.new_acceleration <= j_r.item.acceleration;
          res_r.still_active     <= 1'b0;
        end
        if (j_r.item.axis == AXIS_Z)              oob_r <= 1'b0;
        else if (j_r.item.active && outside)      oob_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid = res_v_r;
  assign out_ch.data  = res_r;
endmodule
`default_nettype wire

// ===== src/velocity_verlet_particle_update_top.sv =====
`default_nettype none
// Velocity Verlet step, one axis per request, three requests per particle.
// A request taken into the datapath passes the bit-serial force/mass divider,
// then three multiply steps and a final step, before it reaches the result
// register; the datapath takes no new request until the last one has been
// loaded into the result register, so one request is in the datapath at a time,
// with a two-entry input queue and a registered result. Config via APB-style
// port at byte address 4*index.
module velocity_verlet_particle_update_top import vvpu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  vvpu_in_if.sink                in_ch,
  vvpu_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  logic [31:0] regs_r [NUM_REGS];
  logic [31:0] bounds [1:6];
  logic [2:0]  ridx;
  vvpu_job_t   job;
  logic        job_valid, job_ready;

  assign ridx       = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (ridx < 3'(NUM_REGS)) ? regs_r[ridx] : '0;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_TIME_STEP] <= 32'd655;
      regs_r[REG_LOWER_X] <= SAT_MIN; regs_r[REG_UPPER_X] <= SAT_MAX;
      regs_r[REG_LOWER_Y] <= SAT_MIN; regs_r[REG_UPPER_Y] <= SAT_MAX;
      regs_r[REG_LOWER_Z] <= SAT_MIN; regs_r[REG_UPPER_Z] <= SAT_MAX;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && ridx < 3'(NUM_REGS)) begin
      regs_r[ridx] <= cfg_pwdata;
    end
  end

  for (genvar g = 1; g <= 6; g++) begin : g_b
    assign bounds[g] = regs_r[g];
  end

  vvpu_front u_front (
    .clk, .rst_n, .in_ch, .bounds, .job, .job_valid, .job_ready
  );

  vvpu_back #(.FracBits(FRAC_BITS)) u_back (
    .clk, .rst_n, .job, .job_valid, .job_ready, .dt(regs_r[REG_TIME_STEP]), .out_ch
  );
endmodule
`default_nettype wire
